/* sv/f12ccw_pkg.sv */
// ---------------------------------------------------------------------------
// f12ccw_pkg
// Shared types, codes and constants of the FAT12 cluster chain walker.
// ---------------------------------------------------------------------------
package f12ccw_pkg;

   // default allocation table size in bytes (power of two)
   localparam int TABLE_BYTES_DEF = 8192;

   // payload widths
   localparam int CLUSTER_W = 12;
   localparam int SECTOR_W  = 32;
   localparam int CSR_W     = 16;

   // root directory size divider: dividend is root_entries * 32
   localparam int DIR_ENTRY_SHIFT = 5;
   localparam int DIV_W           = 16 + DIR_ENTRY_SHIFT;
   localparam int DIV_CNT_W       = $clog2(DIV_W + 1);
   localparam int SB_W            = 13;

   // product widths
   localparam int GEO_PROD_W  = 24;
   localparam int STEP_PROD_W = 20;

   // first cluster of the data area and end of chain marker
   localparam logic [CLUSTER_W-1:0] FIRST_DATA_CLUSTER = 12'd2;
   localparam logic [CLUSTER_W-1:0] END_MARK           = 12'hff8;

   // configuration reset values
   localparam logic [15:0]     RST_RESERVED   = 16'd1;
   localparam logic [7:0]      RST_FAT_COPIES = 8'd2;
   localparam logic [15:0]     RST_SPT        = 16'd9;
   localparam logic [15:0]     RST_ROOT       = 16'd224;
   localparam logic [SB_W-1:0] RST_SECTOR_B   = 13'd512;
   localparam logic [7:0]      RST_CLUS_SECS  = 8'd1;

   typedef enum logic [2:0] {
      CSR_RESERVED_SECTORS  = 3'd0,
      CSR_FAT_COPIES        = 3'd1,
      CSR_SECTORS_PER_TABLE = 3'd2,
      CSR_ROOT_ENTRIES      = 3'd3,
      CSR_SECTOR_BYTES      = 3'd4,
      CSR_CLUSTER_SECTORS   = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      CMD_LOAD    = 2'd0,
      CMD_START   = 2'd1,
      CMD_ADVANCE = 2'd2
   } command_type;

   typedef enum logic [2:0] {
      STS_SECTOR    = 3'd0,
      STS_LOAD_DONE = 3'd1,
      STS_CHAIN_END = 3'd2,
      STS_NO_CHAIN  = 3'd3,
      STS_INVALID   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_LO,
      ST_RD_HI,
      ST_MUL,
      ST_ADD,
      ST_FIN
   } state_type;

   typedef enum logic [1:0] {
      GEO_LOAD,
      GEO_RUN,
      GEO_SUM,
      GEO_READY
   } geo_state_type;

endpackage

/* sv/fat12_cluster_chain_walker.sv */
// From the accepting edge, a load passes through the finish state to the output
// register; a start passes through multiply, add and finish; an advance passes
// through two table byte reads, one multiply, one add and finish. One item is in
// flight at a time: the next item is taken once the previous one has reached the
// output register. After reset and after every configuration write the data area
// base is rebuilt by a bit-serial divider, during which req_stall stays high.
// ---------------------------------------------------------------------------
// fat12_cluster_chain_walker
// Holds a FAT12 allocation table in a byte RAM and follows a cluster chain,
// returning the first data sector of each cluster. TABLE_BYTES must be a power of two; the block does not enforce it.
// ---------------------------------------------------------------------------
module fat12_cluster_chain_walker #(
   parameter int TABLE_BYTES = f12ccw_pkg::TABLE_BYTES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // item input
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_command,
   input  logic [$clog2(TABLE_BYTES)-1:0]      req_table_address,
   input  logic [7:0]                          req_table_byte,
   input  logic [f12ccw_pkg::CLUSTER_W-1:0]    req_first_cluster,
   // result output
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [2:0]                          rsp_status,
   output logic [f12ccw_pkg::SECTOR_W-1:0]     rsp_sector_address,
   output logic [f12ccw_pkg::CLUSTER_W-1:0]    rsp_cluster_number,
   // configuration writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [2:0]                          csr_index,
   input  logic [f12ccw_pkg::CSR_W-1:0]        csr_data
);

   localparam int AW = $clog2(TABLE_BYTES);
   localparam int SW = (AW > 14) ? AW : 14;
   localparam int CW = f12ccw_pkg::CLUSTER_W;

   // configuration registers
   logic [15:0]                  reserved_ff;
   logic [7:0]                   fat_copies_ff;
   logic [15:0]                  spt_ff;
   logic [15:0]                  root_ff;
   logic [f12ccw_pkg::SB_W-1:0]  sector_bytes_ff;
   logic [7:0]                   clus_secs_ff;
   logic                         csr_write;

   // geometry unit
   f12ccw_pkg::geo_state_type       geo_ff, geo_in;
   logic [f12ccw_pkg::DIV_W-1:0]    quo_ff, quo_in;
   logic [f12ccw_pkg::SB_W-1:0]     rem_ff, rem_in;
   logic [f12ccw_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [f12ccw_pkg::GEO_PROD_W-1:0] geo_prod_ff;
   logic [f12ccw_pkg::SECTOR_W-1:0] base_ff, base_in;
   logic [f12ccw_pkg::SB_W-1:0]     den;
   logic [f12ccw_pkg::SB_W:0]       rem_sh;
   logic                            geo_ready;

   // chain walker
   f12ccw_pkg::state_type            state_ff, state_in;
   logic                             active_ff, active_in;
   logic [CW-1:0]                    cur_ff, cur_in;
   logic [AW-1:0]                    at_ff, at_in;
   logic [7:0]                       lo_ff, lo_in;
   logic [f12ccw_pkg::STEP_PROD_W-1:0] step_prod_ff, step_prod_in;
   logic [2:0]                       res_status_ff, res_status_in;
   logic [f12ccw_pkg::SECTOR_W-1:0]  res_sector_ff, res_sector_in;
   logic [CW-1:0]                    res_cluster_ff, res_cluster_in;

   // output register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [2:0]                       rsp_status_ff, rsp_status_in;
   logic [f12ccw_pkg::SECTOR_W-1:0]  rsp_sector_ff, rsp_sector_in;
   logic [CW-1:0]                    rsp_cluster_ff, rsp_cluster_in;

   // table RAM ports
   logic          ram_we;
   logic [AW-1:0] ram_rd_addr;
   logic [7:0]    ram_rd_data;

   logic          req_accept;
   logic [SW-1:0] at_sum;
   logic [AW-1:0] at_now;
   logic [15:0]   entry_word;
   logic [CW-1:0] next_cl;
   logic [CW-1:0] cl_off;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   // configuration register file
   always_ff @(posedge clock) begin
      if (reset) begin
         reserved_ff     <= f12ccw_pkg::RST_RESERVED;
         fat_copies_ff   <= f12ccw_pkg::RST_FAT_COPIES;
         spt_ff          <= f12ccw_pkg::RST_SPT;
         root_ff         <= f12ccw_pkg::RST_ROOT;
         sector_bytes_ff <= f12ccw_pkg::RST_SECTOR_B;
         clus_secs_ff    <= f12ccw_pkg::RST_CLUS_SECS;
      end else if (csr_write) begin
         case (csr_index)
            f12ccw_pkg::CSR_RESERVED_SECTORS:  reserved_ff     <= csr_data;
            f12ccw_pkg::CSR_FAT_COPIES:        fat_copies_ff   <= csr_data[7:0];
            f12ccw_pkg::CSR_SECTORS_PER_TABLE: spt_ff          <= csr_data;
            f12ccw_pkg::CSR_ROOT_ENTRIES:      root_ff         <= csr_data;
            f12ccw_pkg::CSR_SECTOR_BYTES:      sector_bytes_ff <= csr_data[f12ccw_pkg::SB_W-1:0];
            f12ccw_pkg::CSR_CLUSTER_SECTORS:   clus_secs_ff    <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   // data area base: reserved + copies * table size + root dir sectors rounded up
   assign den    = (sector_bytes_ff == '0) ? f12ccw_pkg::SB_W'(1) : sector_bytes_ff;
   assign rem_sh = {rem_ff, quo_ff[f12ccw_pkg::DIV_W-1]};

   always_comb begin
      geo_in  = geo_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      base_in = base_ff;
      case (geo_ff)
         f12ccw_pkg::GEO_LOAD: begin
            quo_in = {root_ff, f12ccw_pkg::DIR_ENTRY_SHIFT'(0)};
            rem_in = '0;
            cnt_in = f12ccw_pkg::DIV_CNT_W'(f12ccw_pkg::DIV_W);
            geo_in = f12ccw_pkg::GEO_RUN;
         end
         f12ccw_pkg::GEO_RUN: begin
            // one quotient bit per cycle, restoring
            if (rem_sh >= {1'b0, den}) begin
               rem_in = f12ccw_pkg::SB_W'(rem_sh - {1'b0, den});
               quo_in = {quo_ff[f12ccw_pkg::DIV_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[f12ccw_pkg::SB_W-1:0];
               quo_in = {quo_ff[f12ccw_pkg::DIV_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == f12ccw_pkg::DIV_CNT_W'(1)) begin
               geo_in = f12ccw_pkg::GEO_SUM;
            end
         end
         f12ccw_pkg::GEO_SUM: begin
            base_in = f12ccw_pkg::SECTOR_W'(reserved_ff)
                    + f12ccw_pkg::SECTOR_W'(geo_prod_ff)
                    + f12ccw_pkg::SECTOR_W'(quo_ff)
                    + f12ccw_pkg::SECTOR_W'(rem_ff != '0);
            geo_in  = f12ccw_pkg::GEO_READY;
         end
         default: begin
         end
      endcase
      if (csr_write) begin
         geo_in = f12ccw_pkg::GEO_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         geo_ff <= f12ccw_pkg::GEO_LOAD;
      end else begin
         geo_ff <= geo_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      base_ff     <= base_in;
      geo_prod_ff <= f12ccw_pkg::GEO_PROD_W'(fat_copies_ff) * f12ccw_pkg::GEO_PROD_W'(spt_ff);
   end

   assign geo_ready = (geo_ff == f12ccw_pkg::GEO_READY);

   // handshake
   assign req_stall  = !((state_ff == f12ccw_pkg::ST_IDLE) && geo_ready);
   assign req_accept = req_valid & ~req_stall;

   // table byte of the current entry: cluster + cluster / 2
   assign at_sum      = SW'(cur_ff) + SW'(cur_ff[CW-1:1]);
   assign at_now      = at_sum[AW-1:0];
   assign ram_rd_addr = (state_ff == f12ccw_pkg::ST_IDLE) ? at_now : at_ff + 1'b1;

   // 12-bit entry: low bits for even cluster, upper bits for odd
   assign entry_word = {ram_rd_data, lo_ff};
   assign next_cl    = cur_ff[0] ? entry_word[15:4] : entry_word[11:0];
   assign cl_off     = res_cluster_ff - f12ccw_pkg::FIRST_DATA_CLUSTER;

   // chain walker next state
   always_comb begin
      state_in       = state_ff;
      active_in      = active_ff;
      cur_in         = cur_ff;
      at_in          = at_ff;
      lo_in          = lo_ff;
      step_prod_in   = step_prod_ff;
      res_status_in  = res_status_ff;
      res_sector_in  = res_sector_ff;
      res_cluster_in = res_cluster_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_sector_in  = rsp_sector_ff;
      rsp_cluster_in = rsp_cluster_ff;
      ram_we         = 1'b0;
      case (state_ff)
         f12ccw_pkg::ST_IDLE: begin
            if (req_accept) begin
               case (req_command)
                  f12ccw_pkg::CMD_LOAD: begin
                     ram_we         = 1'b1;
                     res_status_in  = f12ccw_pkg::STS_LOAD_DONE;
                     res_sector_in  = '0;
                     res_cluster_in = '0;
                     state_in       = f12ccw_pkg::ST_FIN;
                  end
                  f12ccw_pkg::CMD_START: begin
                     res_cluster_in = req_first_cluster;
                     if (req_first_cluster < f12ccw_pkg::FIRST_DATA_CLUSTER) begin
                        active_in     = 1'b0;
                        res_status_in = f12ccw_pkg::STS_INVALID;
                        res_sector_in = '0;
                        state_in      = f12ccw_pkg::ST_FIN;
                     end else begin
                        active_in     = 1'b1;
                        cur_in        = req_first_cluster;
                        res_status_in = f12ccw_pkg::STS_SECTOR;
                        state_in      = f12ccw_pkg::ST_MUL;
                     end
                  end
                  default: begin
                     // advance; command three decodes the same way
                     if (!active_ff) begin
                        res_status_in  = f12ccw_pkg::STS_NO_CHAIN;
                        res_sector_in  = '0;
                        res_cluster_in = '0;
                        state_in       = f12ccw_pkg::ST_FIN;
                     end else begin
                        at_in    = at_now;
                        state_in = f12ccw_pkg::ST_RD_LO;
                     end
                  end
               endcase
            end
         end
         f12ccw_pkg::ST_RD_LO: begin
            lo_in    = ram_rd_data;
            state_in = f12ccw_pkg::ST_RD_HI;
         end
         f12ccw_pkg::ST_RD_HI: begin
            res_cluster_in = next_cl;
            if (next_cl >= f12ccw_pkg::END_MARK) begin
               active_in     = 1'b0;
               res_status_in = f12ccw_pkg::STS_CHAIN_END;
               res_sector_in = '0;
               state_in      = f12ccw_pkg::ST_FIN;
            end else if (next_cl < f12ccw_pkg::FIRST_DATA_CLUSTER) begin
               active_in     = 1'b0;
               res_status_in = f12ccw_pkg::STS_INVALID;
               res_sector_in = '0;
               state_in      = f12ccw_pkg::ST_FIN;
            end else begin
               cur_in        = next_cl;
               res_status_in = f12ccw_pkg::STS_SECTOR;
               state_in      = f12ccw_pkg::ST_MUL;
            end
         end
         f12ccw_pkg::ST_MUL: begin
            step_prod_in = f12ccw_pkg::STEP_PROD_W'(cl_off)
                         * f12ccw_pkg::STEP_PROD_W'(clus_secs_ff);
            state_in     = f12ccw_pkg::ST_ADD;
         end
         f12ccw_pkg::ST_ADD: begin
            res_sector_in = base_ff + f12ccw_pkg::SECTOR_W'(step_prod_ff);
            state_in      = f12ccw_pkg::ST_FIN;
         end
         f12ccw_pkg::ST_FIN: begin
            // hand the item to the output register once it is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_sector_in  = res_sector_ff;
               rsp_cluster_in = res_cluster_ff;
               state_in       = f12ccw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = f12ccw_pkg::ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= f12ccw_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      at_ff          <= at_in;
      lo_ff          <= lo_in;
      step_prod_ff   <= step_prod_in;
      res_status_ff  <= res_status_in;
      res_sector_ff  <= res_sector_in;
      res_cluster_ff <= res_cluster_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_sector_ff  <= rsp_sector_in;
      rsp_cluster_ff <= rsp_cluster_in;
   end

   // allocation table store
   f12ccw_ram #(
      .WIDTH (8),
      .DEPTH (TABLE_BYTES)
   ) u_table_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (req_table_address),
      .wr_data (req_table_byte),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_sector_address = rsp_sector_ff;
   assign rsp_cluster_number = rsp_cluster_ff;

endmodule

/* sv/f12ccw_ram.sv */
// ---------------------------------------------------------------------------
// f12ccw_ram
// Generic single write port, single read port RAM with registered read data.
// ---------------------------------------------------------------------------
module f12ccw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
